### hw/rtl/lce_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers for the Lagrange coefficient engine.
// No dependencies; every file but lce_ram and lce_queue imports it.
package lce_pkg;

   localparam int MAX_POINTS_DEF = 16;
   localparam int PT_W           = 32;
   localparam int COEF_W         = 64;
   localparam int POW_W          = 6;
   localparam int MAG_B_W        = 33;
   localparam int PROD_W         = 97;
   localparam int NUM_W          = 112;
   localparam int DIV_CNT_W      = 7;

   localparam logic [COEF_W-1:0] ONE_Q32 = 64'h0000_0001_0000_0000;
   localparam logic [COEF_W-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [COEF_W-1:0] NEG_MIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic                 start;
      logic [COEF_W-1:0]    a_mag;
      logic [MAG_B_W-1:0]   b_mag;
      logic                 neg;
   } mul_req_type;

   typedef struct packed {
      logic                 done;
      logic [COEF_W-1:0]    result;
      logic                 ovf;
      logic [PROD_W-1:0]    prod;
   } mul_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [NUM_W-1:0]     num;
      logic [COEF_W-1:0]    den;
      logic                 neg;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [COEF_W-1:0]    result;
      logic                 ovf;
   } div_rsp_type;

   typedef enum logic [2:0] {
      MUL_IDLE, MUL_LO, MUL_HI, MUL_ADD, MUL_RND, MUL_SAT
   } mul_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE, DIV_RUN, DIV_RND, DIV_SAT
   } div_state_type;

   typedef enum logic [4:0] {
      BK_IDLE, BK_DUP_RDI, BK_DUP_GETI, BK_DUP_RDM, BK_DUP_CMP,
      BK_PT_RD, BK_PT_GET, BK_M_CHECK, BK_M_GET, BK_B_TOP, BK_B_MUL,
      BK_B_PREV, BK_B_WAIT, BK_D_MUL, BK_D_WAIT, BK_T_RD, BK_T_GET,
      BK_T_MWAIT, BK_T_DWAIT, BK_T_ACC, BK_O_RD, BK_O_EMIT
   } back_state_type;

   function automatic logic [COEF_W-1:0] mag64(input logic [COEF_W-1:0] v);
      return v[COEF_W-1] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [MAG_B_W-1:0] mag33(input logic [PT_W-1:0] v);
      logic [MAG_B_W-1:0] s;
      s = {v[PT_W-1], v};
      return v[PT_W-1] ? (33'd0 - s) : s;
   endfunction

   // {overflow, value}
   function automatic logic [COEF_W:0] sat_add(input logic [COEF_W-1:0] a,
                                               input logic [COEF_W-1:0] b);
      logic [COEF_W-1:0] s;
      s = a + b;
      if (a[COEF_W-1] == b[COEF_W-1] && s[COEF_W-1] != a[COEF_W-1])
         return {1'b1, a[COEF_W-1] ? NEG_MIN : POS_MAX};
      return {1'b0, s};
   endfunction

   function automatic logic [COEF_W:0] sat_sub(input logic [COEF_W-1:0] a,
                                               input logic [COEF_W-1:0] b);
      logic [COEF_W-1:0] s;
      s = a - b;
      if (a[COEF_W-1] != b[COEF_W-1] && s[COEF_W-1] != a[COEF_W-1])
         return {1'b1, a[COEF_W-1] ? NEG_MIN : POS_MAX};
      return {1'b0, s};
   endfunction

endpackage

### hw/rtl/lagrange_coefficient_engine_unit.sv
`timescale 1ns / 1ps
// Top level of the Lagrange coefficient engine: point loader, run queue, solver,
// shared multiplier and divider, point store. Depends on lce_pkg and all lce_ modules.
//
//   channel   ports                                   beat taken when
//   -------   -------------------------------------   ---------------------------
//   request   req_point_x, req_point_y, req_last_point start && !busy
//   result    rsp_coefficient, rsp_power, rsp_overflow, rsp_strobe (one cycle each)
//             rsp_duplicate_x, rsp_last_coefficient
//
// The last point starts a run; busy stays high until the constant term is out. A run
// does a duplicate check, then, if no x repeats, a basis build whose multiply-subtracts use
// the shared multiplier, then scaled terms from the bit-serial divider (n*n terms per run).
// Reset is synchronous and clears the point count, run queue and all sequencers; it needs
// no clearing pass. Results cannot be held off.
module lagrange_coefficient_engine_unit #(
   parameter int MAX_POINTS = lce_pkg::MAX_POINTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [lce_pkg::PT_W-1:0]   req_point_x,
   input  logic signed [lce_pkg::PT_W-1:0]   req_point_y,
   input  logic                              req_last_point,
   output logic                              rsp_strobe,
   output logic signed [lce_pkg::COEF_W-1:0] rsp_coefficient,
   output logic [lce_pkg::POW_W-1:0]         rsp_power,
   output logic                              rsp_overflow,
   output logic                              rsp_duplicate_x,
   output logic                              rsp_last_coefficient
);
   import lce_pkg::*;

   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int IW = $clog2(MAX_POINTS);

   logic              pt_we;
   logic [IW-1:0]     pt_waddr, pt_raddr;
   logic [2*PT_W-1:0] pt_wdata, pt_rdata;
   logic              push, pop, q_empty, q_full;
   logic [CW-1:0]     push_n, q_n;
   logic              back_active;
   mul_req_type       mul_req;
   mul_rsp_type       mul_rsp;
   div_req_type       div_req;
   div_rsp_type       div_rsp;
   logic [COEF_W-1:0] coef;

   lce_front #(.MAX_POINTS(MAX_POINTS), .CW(CW), .IW(IW)) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .point_x     (req_point_x),
      .point_y     (req_point_y),
      .last_point  (req_last_point),
      .q_empty     (q_empty),
      .back_active (back_active || q_full),
      .wr_en       (pt_we),
      .wr_addr     (pt_waddr),
      .wr_data     (pt_wdata),
      .push        (push),
      .push_n      (push_n)
   );

   lce_ram #(.WIDTH(2 * PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (pt_waddr),
      .wr_data (pt_wdata),
      .rd_addr (pt_raddr),
      .rd_data (pt_rdata)
   );

   lce_queue #(.WIDTH(CW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_n),
      .pop       (pop),
      .pop_data  (q_n),
      .empty     (q_empty),
      .full      (q_full)
   );

   lce_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   lce_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   lce_back #(.MAX_POINTS(MAX_POINTS), .CW(CW), .IW(IW)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_n             (q_n),
      .pop             (pop),
      .active          (back_active),
      .pt_rd_addr      (pt_raddr),
      .pt_rd_data      (pt_rdata),
      .mul_req         (mul_req),
      .mul_rsp         (mul_rsp),
      .div_req         (div_req),
      .div_rsp         (div_rsp),
      .res_strobe      (rsp_strobe),
      .res_coefficient (coef),
      .res_power       (rsp_power),
      .res_overflow    (rsp_overflow),
      .res_duplicate_x (rsp_duplicate_x),
      .res_last        (rsp_last_coefficient)
   );

   assign rsp_coefficient = $signed(coef);
endmodule

### hw/rtl/lce_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lce_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/lce_queue.sv
`timescale 1ns / 1ps
// Two-entry run queue between the point loader and the solver.
// No dependencies.
module lce_queue #(
   parameter int WIDTH = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);
   logic [WIDTH-1:0] entry_ff [2];
   logic [WIDTH-1:0] entry_in [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign empty    = (cnt_ff == 2'd0);
   assign full     = (cnt_ff == 2'd2);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      entry_in = entry_ff;
      if (do_push) begin
         entry_in[wr_ptr_ff] = push_data;
      end
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule

### hw/rtl/lce_mul.sv
`timescale 1ns / 1ps
// Shared multicycle 64 x 33 magnitude multiplier: Q32.32 times Q16.16, rounded and saturated to Q32.32.
// Depends on lce_pkg.
module lce_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  lce_pkg::mul_req_type req,
   output lce_pkg::mul_rsp_type rsp
);
   import lce_pkg::*;

   mul_state_type       state_ff, state_in;
   logic [COEF_W-1:0]   a_ff, a_in;
   logic [MAG_B_W-1:0]  b_ff, b_in;
   logic                neg_ff, neg_in;
   logic [64:0]         pl_ff, pl_in;
   logic [64:0]         ph_ff, ph_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [81:0]         q_ff, q_in;
   logic [COEF_W-1:0]   res_ff, res_in;
   logic                ovf_ff, ovf_in;
   logic                done_ff, done_in;
   logic [PROD_W:0]     rnd_w;

   assign rnd_w = {1'b0, prod_ff} + 98'h8000;

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      neg_in   = neg_ff;
      pl_in    = pl_ff;
      ph_in    = ph_ff;
      prod_in  = prod_ff;
      q_in     = q_ff;
      res_in   = res_ff;
      ovf_in   = ovf_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         MUL_IDLE: begin
            if (req.start) begin
               a_in     = req.a_mag;
               b_in     = req.b_mag;
               neg_in   = req.neg;
               state_in = MUL_LO;
            end
         end
         MUL_LO: begin
            pl_in    = 65'(b_ff * a_ff[31:0]);
            state_in = MUL_HI;
         end
         MUL_HI: begin
            ph_in    = 65'(b_ff * a_ff[63:32]);
            state_in = MUL_ADD;
         end
         MUL_ADD: begin
            prod_in  = {32'd0, pl_ff} + {ph_ff, 32'd0};
            state_in = MUL_RND;
         end
         MUL_RND: begin
            q_in     = rnd_w[PROD_W:16];
            state_in = MUL_SAT;
         end
         MUL_SAT: begin
            if (!neg_ff) begin
               ovf_in = |q_ff[81:63];
               res_in = ovf_in ? POS_MAX : q_ff[63:0];
            end else begin
               ovf_in = (|q_ff[81:64]) || (q_ff[63] && (|q_ff[62:0]));
               res_in = ovf_in ? NEG_MIN : (64'd0 - q_ff[63:0]);
            end
            done_in  = 1'b1;
            state_in = MUL_IDLE;
         end
         default: state_in = MUL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      neg_ff  <= neg_in;
      pl_ff   <= pl_in;
      ph_ff   <= ph_in;
      prod_ff <= prod_in;
      q_ff    <= q_in;
      res_ff  <= res_in;
      ovf_ff  <= ovf_in;
      if (reset) begin
         state_ff <= MUL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;
   assign rsp.ovf    = ovf_ff;
   assign rsp.prod   = prod_ff;
endmodule

### hw/rtl/lce_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, 112-bit numerator by 64-bit divisor, one bit a cycle,
// rounding half away from zero and saturating to signed 64 bits. Depends on lce_pkg.
module lce_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lce_pkg::div_req_type req,
   output lce_pkg::div_rsp_type rsp
);
   import lce_pkg::*;

   div_state_type        state_ff, state_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [NUM_W-1:0]     q_ff, q_in;
   logic [NUM_W:0]       qr_ff, qr_in;
   logic [COEF_W-1:0]    rem_ff, rem_in;
   logic [COEF_W-1:0]    den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [COEF_W-1:0]    res_ff, res_in;
   logic                 ovf_ff, ovf_in;
   logic                 done_ff, done_in;
   logic [COEF_W:0]      rem_sh_w;
   logic                 ge_w;
   logic                 rnd_w;

   assign rem_sh_w = {rem_ff, num_ff[NUM_W-1]};
   assign ge_w     = rem_sh_w >= {1'b0, den_ff};
   assign rnd_w    = {rem_ff, 1'b0} >= {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      q_in     = q_ff;
      qr_in    = qr_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      ovf_in   = ovf_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         DIV_IDLE: begin
            if (req.start) begin
               num_in   = req.num;
               den_in   = req.den;
               neg_in   = req.neg;
               rem_in   = '0;
               q_in     = '0;
               cnt_in   = DIV_CNT_W'(NUM_W - 1);
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            rem_in = ge_w ? COEF_W'(rem_sh_w - {1'b0, den_ff}) : rem_sh_w[COEF_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], ge_w};
            num_in = {num_ff[NUM_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = DIV_RND;
            end
         end
         DIV_RND: begin
            qr_in    = {1'b0, q_ff} + {{NUM_W{1'b0}}, rnd_w};
            state_in = DIV_SAT;
         end
         DIV_SAT: begin
            if (!neg_ff) begin
               ovf_in = |qr_ff[NUM_W:63];
               res_in = ovf_in ? POS_MAX : qr_ff[63:0];
            end else begin
               ovf_in = (|qr_ff[NUM_W:64]) || (qr_ff[63] && (|qr_ff[62:0]));
               res_in = ovf_in ? NEG_MIN : (64'd0 - qr_ff[63:0]);
            end
            done_in  = 1'b1;
            state_in = DIV_IDLE;
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      q_ff   <= q_in;
      qr_ff  <= qr_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      ovf_ff <= ovf_in;
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;
   assign rsp.ovf    = ovf_ff;
endmodule

### hw/rtl/lce_front.sv
`timescale 1ns / 1ps
// Point loader: takes sample points, writes the point store, counts the set and
// queues a run when the last point arrives. Depends on lce_pkg.
module lce_front #(
   parameter int MAX_POINTS = lce_pkg::MAX_POINTS_DEF,
   parameter int CW         = $clog2(MAX_POINTS + 1),
   parameter int IW         = $clog2(MAX_POINTS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [lce_pkg::PT_W-1:0] point_x,
   input  logic [lce_pkg::PT_W-1:0] point_y,
   input  logic                  last_point,
   input  logic                  q_empty,
   input  logic                  back_active,
   output logic                  wr_en,
   output logic [IW-1:0]         wr_addr,
   output logic [2*lce_pkg::PT_W-1:0] wr_data,
   output logic                  push,
   output logic [CW-1:0]         push_n
);
   import lce_pkg::*;

   logic [CW-1:0] count_ff, count_in;
   logic          accept;
   logic          full;
   logic [CW-1:0] count_nx;

   // hold off new points while a run waits or executes
   assign busy     = !q_empty || back_active;
   assign accept   = start && !busy;
   assign full     = (count_ff == CW'(MAX_POINTS));
   assign count_nx = full ? count_ff : count_ff + 1'b1;

   assign wr_en   = accept && !full;
   assign wr_addr = count_ff[IW-1:0];
   assign wr_data = {point_x, point_y};
   assign push    = accept && last_point;
   assign push_n  = count_nx;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = last_point ? '0 : count_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule

### hw/rtl/lce_back.sv
`timescale 1ns / 1ps
// Solver sequencer: duplicate check, basis build, scaling and summing, coefficient
// output. Depends on lce_pkg and lce_ram; drives the shared multiplier and divider.
module lce_back #(
   parameter int MAX_POINTS = lce_pkg::MAX_POINTS_DEF,
   parameter int CW         = $clog2(MAX_POINTS + 1),
   parameter int IW         = $clog2(MAX_POINTS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  logic [CW-1:0]               q_n,
   output logic                        pop,
   output logic                        active,
   output logic [IW-1:0]               pt_rd_addr,
   input  logic [2*lce_pkg::PT_W-1:0]  pt_rd_data,
   output lce_pkg::mul_req_type        mul_req,
   input  lce_pkg::mul_rsp_type        mul_rsp,
   output lce_pkg::div_req_type        div_req,
   input  lce_pkg::div_rsp_type        div_rsp,
   output logic                        res_strobe,
   output logic [lce_pkg::COEF_W-1:0]  res_coefficient,
   output logic [lce_pkg::POW_W-1:0]   res_power,
   output logic                        res_overflow,
   output logic                        res_duplicate_x,
   output logic                        res_last
);
   import lce_pkg::*;

   back_state_type    state_ff, state_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [CW-1:0]     i_ff, i_in;
   logic [CW-1:0]     m_ff, m_in;
   logic [IW-1:0]     p_ff, p_in;
   logic [IW-1:0]     deg_ff, deg_in;
   logic [IW-1:0]     pw_ff, pw_in;
   logic              dup_ff, dup_in;
   logic [PT_W-1:0]   xi_ff, xi_in;
   logic [PT_W-1:0]   yi_ff, yi_in;
   logic [PT_W-1:0]   xm_ff, xm_in;
   logic [COEF_W:0]   cur_ff, cur_in;
   logic [COEF_W:0]   prev_ff, prev_in;
   logic [COEF_W-1:0] den_ff, den_in;
   logic              dov_ff, dov_in;
   logic              tneg_ff, tneg_in;
   logic [COEF_W-1:0] term_ff, term_in;
   logic              tov_ff, tov_in;
   logic [MAX_POINTS-1:0] cvalid_ff, cvalid_in;

   logic              strobe_ff, strobe_in;
   logic [COEF_W-1:0] coef_ff, coef_in;
   logic [POW_W-1:0]  pow_ff, pow_in;
   logic              ovf_o_ff, ovf_o_in;
   logic              dup_o_ff, dup_o_in;
   logic              last_o_ff, last_o_in;

   logic              pt_sel_i;
   logic              b_we, c_we;
   logic [IW-1:0]     b_waddr, b_raddr, c_waddr, c_raddr;
   logic [COEF_W:0]   b_wdata, b_rdata, c_wdata, c_rdata;
   logic [PT_W:0]     diff_w;
   logic [MAG_B_W-1:0] diff_mag;
   logic [COEF_W:0]   sub_w;
   logic [COEF_W:0]   old_w;
   logic [COEF_W:0]   add_w;

   assign diff_w   = {xi_ff[PT_W-1], xi_ff} - {xm_ff[PT_W-1], xm_ff};
   assign diff_mag = diff_w[PT_W] ? (33'd0 - diff_w) : diff_w;
   assign sub_w    = sat_sub((p_ff != '0) ? prev_ff[COEF_W-1:0] : 64'd0, mul_rsp.result);
   assign old_w    = cvalid_ff[p_ff] ? c_rdata : '0;
   assign add_w    = sat_add(old_w[COEF_W-1:0], term_ff);
   assign pt_rd_addr = pt_sel_i ? i_ff[IW-1:0] : m_ff[IW-1:0];
   assign active   = (state_ff != BK_IDLE);

   lce_ram #(.WIDTH(COEF_W + 1), .DEPTH(MAX_POINTS)) u_basis_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   lce_ram #(.WIDTH(COEF_W + 1), .DEPTH(MAX_POINTS)) u_coeff_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_addr (c_raddr),
      .rd_data (c_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      m_in      = m_ff;
      p_in      = p_ff;
      deg_in    = deg_ff;
      pw_in     = pw_ff;
      dup_in    = dup_ff;
      xi_in     = xi_ff;
      yi_in     = yi_ff;
      xm_in     = xm_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      den_in    = den_ff;
      dov_in    = dov_ff;
      tneg_in   = tneg_ff;
      term_in   = term_ff;
      tov_in    = tov_ff;
      cvalid_in = cvalid_ff;
      strobe_in = 1'b0;
      coef_in   = coef_ff;
      pow_in    = pow_ff;
      ovf_o_in  = ovf_o_ff;
      dup_o_in  = dup_o_ff;
      last_o_in = last_o_ff;
      pop       = 1'b0;
      pt_sel_i  = 1'b0;
      b_we      = 1'b0;
      b_waddr   = p_ff;
      b_wdata   = '0;
      b_raddr   = p_ff;
      c_we      = 1'b0;
      c_waddr   = p_ff;
      c_wdata   = '0;
      c_raddr   = p_ff;
      mul_req   = '0;
      div_req   = '0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               pop       = 1'b1;
               n_in      = q_n;
               i_in      = '0;
               dup_in    = 1'b0;
               cvalid_in = '0;
               state_in  = BK_DUP_RDI;
            end
         end
         BK_DUP_RDI: begin
            pt_sel_i = 1'b1;
            if (({1'b0, i_ff} + 1'b1) >= {1'b0, n_ff}) begin
               if (dup_ff) begin
                  pw_in    = IW'(n_ff - 1'b1);
                  state_in = BK_O_RD;
               end else begin
                  i_in     = '0;
                  state_in = BK_PT_RD;
               end
            end else begin
               state_in = BK_DUP_GETI;
            end
         end
         BK_DUP_GETI: begin
            xi_in    = pt_rd_data[2*PT_W-1:PT_W];
            m_in     = i_ff + 1'b1;
            state_in = BK_DUP_RDM;
         end
         BK_DUP_RDM: begin
            state_in = BK_DUP_CMP;
         end
         BK_DUP_CMP: begin
            if (pt_rd_data[2*PT_W-1:PT_W] == xi_ff) begin
               dup_in = 1'b1;
            end
            m_in = m_ff + 1'b1;
            if ((m_ff + 1'b1) == n_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = BK_DUP_RDI;
            end else begin
               state_in = BK_DUP_RDM;
            end
         end
         BK_PT_RD: begin
            pt_sel_i = 1'b1;
            state_in = BK_PT_GET;
         end
         BK_PT_GET: begin
            xi_in    = pt_rd_data[2*PT_W-1:PT_W];
            yi_in    = pt_rd_data[PT_W-1:0];
            den_in   = ONE_Q32;
            dov_in   = 1'b0;
            deg_in   = '0;
            m_in     = '0;
            b_we     = 1'b1;
            b_waddr  = '0;
            b_wdata  = {1'b0, ONE_Q32};
            state_in = BK_M_CHECK;
         end
         BK_M_CHECK: begin
            if (m_ff == n_ff) begin
               p_in     = '0;
               state_in = BK_T_RD;
            end else if (m_ff == i_ff) begin
               m_in = m_ff + 1'b1;
            end else begin
               state_in = BK_M_GET;
            end
         end
         BK_M_GET: begin
            xm_in    = pt_rd_data[2*PT_W-1:PT_W];
            b_raddr  = deg_ff;
            state_in = BK_B_TOP;
         end
         BK_B_TOP: begin
            // raise the degree: top coefficient moves up one place
            cur_in   = b_rdata;
            b_we     = 1'b1;
            b_waddr  = deg_ff + 1'b1;
            b_wdata  = b_rdata;
            p_in     = deg_ff;
            state_in = BK_B_MUL;
         end
         BK_B_MUL: begin
            mul_req.start = 1'b1;
            mul_req.a_mag = mag64(cur_ff[COEF_W-1:0]);
            mul_req.b_mag = mag33(xm_ff);
            mul_req.neg   = cur_ff[COEF_W-1] ^ xm_ff[PT_W-1];
            b_raddr       = p_ff - 1'b1;
            state_in      = BK_B_PREV;
         end
         BK_B_PREV: begin
            prev_in  = b_rdata;
            state_in = BK_B_WAIT;
         end
         BK_B_WAIT: begin
            if (mul_rsp.done) begin
               b_we    = 1'b1;
               b_waddr = p_ff;
               if (p_ff != '0) begin
                  b_wdata  = {cur_ff[COEF_W] | prev_ff[COEF_W] | mul_rsp.ovf | sub_w[COEF_W],
                              sub_w[COEF_W-1:0]};
                  cur_in   = prev_ff;
                  p_in     = p_ff - 1'b1;
                  state_in = BK_B_MUL;
               end else begin
                  b_wdata  = {cur_ff[COEF_W] | mul_rsp.ovf | sub_w[COEF_W],
                              sub_w[COEF_W-1:0]};
                  state_in = BK_D_MUL;
               end
            end
         end
         BK_D_MUL: begin
            mul_req.start = 1'b1;
            mul_req.a_mag = mag64(den_ff);
            mul_req.b_mag = diff_mag;
            mul_req.neg   = den_ff[COEF_W-1] ^ diff_w[PT_W];
            state_in      = BK_D_WAIT;
         end
         BK_D_WAIT: begin
            if (mul_rsp.done) begin
               den_in   = mul_rsp.result;
               dov_in   = dov_ff | mul_rsp.ovf;
               deg_in   = deg_ff + 1'b1;
               m_in     = m_ff + 1'b1;
               state_in = BK_M_CHECK;
            end
         end
         BK_T_RD: begin
            state_in = BK_T_GET;
         end
         BK_T_GET: begin
            cur_in        = b_rdata;
            mul_req.start = 1'b1;
            mul_req.a_mag = mag64(b_rdata[COEF_W-1:0]);
            mul_req.b_mag = mag33(yi_ff);
            tneg_in       = b_rdata[COEF_W-1] ^ yi_ff[PT_W-1] ^ den_ff[COEF_W-1];
            state_in      = BK_T_MWAIT;
         end
         BK_T_MWAIT: begin
            if (mul_rsp.done) begin
               if (den_ff == '0) begin
                  // denominator rounded away: saturate any nonzero numerator
                  term_in  = (mul_rsp.prod == '0) ? '0 : (tneg_ff ? NEG_MIN : POS_MAX);
                  tov_in   = (mul_rsp.prod != '0);
                  state_in = BK_T_ACC;
               end else begin
                  div_req.start = 1'b1;
                  div_req.num   = {mul_rsp.prod[95:0], 16'h0000};
                  div_req.den   = mag64(den_ff);
                  div_req.neg   = tneg_ff;
                  state_in      = BK_T_DWAIT;
               end
            end
         end
         BK_T_DWAIT: begin
            if (div_rsp.done) begin
               term_in  = div_rsp.result;
               tov_in   = div_rsp.ovf;
               state_in = BK_T_ACC;
            end
         end
         BK_T_ACC: begin
            c_we               = 1'b1;
            c_wdata            = {old_w[COEF_W] | cur_ff[COEF_W] | dov_ff | tov_ff | add_w[COEF_W],
                                  add_w[COEF_W-1:0]};
            cvalid_in[p_ff]    = 1'b1;
            if (p_ff == deg_ff) begin
               i_in = i_ff + 1'b1;
               if ((i_ff + 1'b1) == n_ff) begin
                  pw_in    = IW'(n_ff - 1'b1);
                  state_in = BK_O_RD;
               end else begin
                  state_in = BK_PT_RD;
               end
            end else begin
               p_in     = p_ff + 1'b1;
               state_in = BK_T_RD;
            end
         end
         BK_O_RD: begin
            c_raddr  = pw_ff;
            state_in = BK_O_EMIT;
         end
         BK_O_EMIT: begin
            c_raddr   = pw_ff;
            strobe_in = 1'b1;
            coef_in   = dup_ff ? '0 : c_rdata[COEF_W-1:0];
            ovf_o_in  = !dup_ff && c_rdata[COEF_W];
            dup_o_in  = dup_ff;
            pow_in    = POW_W'(pw_ff);
            last_o_in = (pw_ff == '0);
            if (pw_ff == '0) begin
               state_in = BK_IDLE;
            end else begin
               pw_in    = pw_ff - 1'b1;
               state_in = BK_O_RD;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      i_ff      <= i_in;
      m_ff      <= m_in;
      p_ff      <= p_in;
      deg_ff    <= deg_in;
      pw_ff     <= pw_in;
      dup_ff    <= dup_in;
      xi_ff     <= xi_in;
      yi_ff     <= yi_in;
      xm_ff     <= xm_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      den_ff    <= den_in;
      dov_ff    <= dov_in;
      tneg_ff   <= tneg_in;
      term_ff   <= term_in;
      tov_ff    <= tov_in;
      cvalid_ff <= cvalid_in;
      coef_ff   <= coef_in;
      pow_ff    <= pow_in;
      ovf_o_ff  <= ovf_o_in;
      dup_o_ff  <= dup_o_in;
      last_o_ff <= last_o_in;
      if (reset) begin
         state_ff  <= BK_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign res_strobe      = strobe_ff;
   assign res_coefficient = coef_ff;
   assign res_power       = pow_ff;
   assign res_overflow    = ovf_o_ff;
   assign res_duplicate_x = dup_o_ff;
   assign res_last        = last_o_ff;
endmodule

### verif/tb_lagrange_coefficient_engine_unit.sv
`timescale 1ns / 1ps
// Testbench for lagrange_coefficient_engine_unit (uses lce_pkg): directed, then random
// sets, each coefficient checked by a fixed-point interpolation predictor or known answer.
module tb_lagrange_coefficient_engine_unit;
   import lce_pkg::*;

   localparam int NPTS       = MAX_POINTS_DEF;
   localparam int ITEM_GOAL  = 210;
   localparam int CYCLE_CAP  = 3000000;

   typedef enum logic [1:0] {CHK_PREDICT, CHK_SINGLE, CHK_DUP} chk_kind_type;

   typedef struct {
      logic [31:0]  x;
      logic [31:0]  y;
      logic         last;
      chk_kind_type kind;
   } point_row_type;

   typedef struct {
      logic [63:0] coef;
      logic [5:0]  pw;
      logic        ovf;
      logic        dup;
      logic        last;
   } coef_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_point_x = '0;
   logic [31:0] req_point_y = '0;
   logic        req_last_point = 1'b0;
   logic        rsp_strobe;
   logic [63:0] rsp_coefficient;
   logic [5:0]  rsp_power;
   logic        rsp_overflow;
   logic        rsp_duplicate_x;
   logic        rsp_last_coefficient;

   coef_beat_type coef_due_q[$];
   logic [63:0]   held_x[NPTS];
   logic [63:0]   held_y[NPTS];
   int            held_count = 0;
   int            error_count = 0;
   int            cycle_count = 0;
   int            items_sent = 0;

   lagrange_coefficient_engine_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_last_point(req_last_point),
      .rsp_strobe(rsp_strobe), .rsp_coefficient(rsp_coefficient),
      .rsp_power(rsp_power), .rsp_overflow(rsp_overflow),
      .rsp_duplicate_x(rsp_duplicate_x), .rsp_last_coefficient(rsp_last_coefficient)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------- fixed-point predictor ----------------
   function automatic logic [63:0] abs64(logic [63:0] v);
      return v[63] ? 64'd0 - v : v;
   endfunction

   function automatic logic [63:0] clamp_wide(logic neg, logic [127:0] m, inout bit ovf);
      if (!neg) begin
         if (m[127:63] != 0) begin
            ovf = 1'b1;
            return POS_MAX;
         end
         return m[63:0];
      end
      if (m > {64'd0, NEG_MIN}) begin
         ovf = 1'b1;
         return NEG_MIN;
      end
      return 64'd0 - m[63:0];
   endfunction

   function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b, inout bit ovf);
      logic [127:0] m;
      m = {64'd0, abs64(a)} * {64'd0, abs64(b)};
      m = (m + 128'h8000) >> 16;
      return clamp_wide(a[63] ^ b[63], m, ovf);
   endfunction

   function automatic logic [63:0] fx_add(logic [63:0] a, logic [63:0] b, inout bit ovf);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         ovf = 1'b1;
         return a[63] ? NEG_MIN : POS_MAX;
      end
      return s;
   endfunction

   function automatic logic [63:0] fx_sub(logic [63:0] a, logic [63:0] b, inout bit ovf);
      logic [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) begin
         ovf = 1'b1;
         return a[63] ? NEG_MIN : POS_MAX;
      end
      return s;
   endfunction

   function automatic logic [63:0] weigh_term(logic [63:0] c, logic [63:0] y,
                                              logic [63:0] p, inout bit ovf);
      logic         neg;
      logic [127:0] num, den, quo, rem;
      neg = c[63] ^ y[63] ^ p[63];
      num = ({64'd0, abs64(c)} * {64'd0, abs64(y)}) << 16;
      den = {64'd0, abs64(p)};
      if (den == 0) begin
         if (num == 0) return 64'd0;
         ovf = 1'b1;
         return neg ? NEG_MIN : POS_MAX;
      end
      quo = num / den;
      rem = num % den;
      if (rem >= den - rem) quo = quo + 1;
      return clamp_wide(neg, quo, ovf);
   endfunction

   // Store one point; on the last point solve the set and queue its coefficients.
   function automatic void take_point(logic [31:0] x, logic [31:0] y, logic last);
      logic [63:0]   basis[NPTS];
      logic [63:0]   sums[NPTS];
      logic [63:0]   den, t;
      bit            bov[NPTS];
      bit            cov[NPTS];
      bit            dov, f, dup;
      int            n, deg;
      coef_beat_type e;
      if (held_count < NPTS) begin
         held_x[held_count] = {{32{x[31]}}, x};
         held_y[held_count] = {{32{y[31]}}, y};
         held_count++;
      end
      if (!last) return;
      n = held_count;
      held_count = 0;
      dup = 1'b0;
      for (int i = 0; i < NPTS; i++) begin
         sums[i] = '0;
         cov[i] = 1'b0;
      end
      for (int i = 0; i < n; i++)
         for (int m = i + 1; m < n; m++)
            if (held_x[i] == held_x[m]) dup = 1'b1;
      for (int i = 0; i < n && !dup; i++) begin
         den = ONE_Q32;
         dov = 1'b0;
         basis[0] = ONE_Q32;
         bov[0] = 1'b0;
         deg = 0;
         for (int m = 0; m < n; m++) begin
            if (m == i) continue;
            basis[deg+1] = basis[deg];
            bov[deg+1] = bov[deg];
            for (int p = deg; p >= 1; p--) begin
               f = 1'b0;
               basis[p] = fx_sub(basis[p-1], fx_mul(held_x[m], basis[p], f), f);
               bov[p] = bov[p] || bov[p-1] || f;
            end
            f = 1'b0;
            basis[0] = fx_sub(64'd0, fx_mul(held_x[m], basis[0], f), f);
            bov[0] = bov[0] || f;
            deg++;
            den = fx_mul(den, held_x[i] - held_x[m], dov);
         end
         for (int p = 0; p <= deg; p++) begin
            f = 1'b0;
            t = weigh_term(basis[p], held_y[i], den, f);
            sums[p] = fx_add(sums[p], t, f);
            cov[p] = cov[p] || bov[p] || dov || f;
         end
      end
      for (int i = 0; i < n; i++) begin
         e.pw   = 6'(n - 1 - i);
         e.coef = dup ? 64'd0 : sums[n-1-i];
         e.ovf  = !dup && cov[n-1-i];
         e.dup  = dup;
         e.last = (n - 1 - i) == 0;
         coef_due_q.insert(coef_due_q.size(), e);
      end
   endfunction

   // ---------------- result checking ----------------
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      coef_beat_type e;
      if (!reset && rsp_strobe) begin
         if (coef_due_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp_coefficient, 64'd0);
         end else begin
            e = coef_due_q.pop_front();
            if (rsp_coefficient !== e.coef) report_mismatch("coefficient", rsp_coefficient, e.coef);
            if (rsp_power !== e.pw) report_mismatch("power", 64'(rsp_power), 64'(e.pw));
            if (rsp_overflow !== e.ovf) report_mismatch("overflow", 64'(rsp_overflow), 64'(e.ovf));
            if (rsp_duplicate_x !== e.dup)
               report_mismatch("duplicate_x", 64'(rsp_duplicate_x), 64'(e.dup));
            if (rsp_last_coefficient !== e.last)
               report_mismatch("last_coefficient", 64'(rsp_last_coefficient), 64'(e.last));
         end
      end
   end

   // ---------------- stimulus ----------------
   // Drive one beat at the falling edge; hold it until busy is low at a rising edge.
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic last, int gap,
                             chk_kind_type kind);
      bit            free;
      int            due_before;
      coef_beat_type e;
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_point_x = x;
      req_point_y = y;
      req_last_point = last;
      forever begin
         #1 free = !busy;
         @(posedge clock);
         if (free) break;
         @(negedge clock);
      end
      due_before = coef_due_q.size();
      take_point(x, y, last);
      // Directed rows with a known answer replace the predicted beats.
      if (kind == CHK_SINGLE) begin
         void'(coef_due_q.pop_back());
         e.coef = {{16{y[31]}}, y, 16'd0};
         e.pw = 6'd0;
         e.ovf = 1'b0;
         e.dup = 1'b0;
         e.last = 1'b1;
         coef_due_q.insert(coef_due_q.size(), e);
      end else if (kind == CHK_DUP) begin
         for (int k = due_before; k < coef_due_q.size(); k++) begin
            coef_due_q[k].coef = 64'd0;
            coef_due_q[k].ovf = 1'b0;
            coef_due_q[k].dup = 1'b1;
         end
      end
      items_sent++;
      @(negedge clock);
   endtask

   point_row_type directed_rows[13] = '{
      '{32'h0000_0000, 32'h7FFF_FFFF, 1'b1, CHK_SINGLE},
      '{32'h8000_0000, 32'h8000_0000, 1'b1, CHK_SINGLE},
      '{32'h0001_0000, 32'h0002_0000, 1'b0, CHK_PREDICT},
      '{32'h0001_0000, 32'hFFFD_0000, 1'b1, CHK_DUP},
      '{32'h7FFF_FFFF, 32'h0000_0001, 1'b0, CHK_PREDICT},
      '{32'h8000_0000, 32'hFFFF_FFFF, 1'b1, CHK_PREDICT},
      '{32'h0000_0000, 32'h0001_0000, 1'b0, CHK_PREDICT},
      '{32'h0001_0000, 32'h0002_0000, 1'b0, CHK_PREDICT},
      '{32'h0002_0000, 32'h0005_0000, 1'b1, CHK_PREDICT},
      // x one ulp apart: the denominator rounds to zero
      '{32'h0000_0000, 32'h0001_0000, 1'b0, CHK_PREDICT},
      '{32'h0000_0001, 32'hFFFF_0000, 1'b0, CHK_PREDICT},
      '{32'h0000_0002, 32'h0000_0000, 1'b0, CHK_PREDICT},
      '{32'h0000_0003, 32'h0003_8000, 1'b1, CHK_PREDICT}
   };

   function automatic logic [31:0] draw_value(int flavor);
      unique case (flavor)
         0:       return 32'($signed($urandom_range(0, 16)) - 8) << 16;
         1:       return $urandom;
         default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   initial begin
      int n, flavor, idle_pct, wait_lim;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      foreach (directed_rows[k])
         send_point(directed_rows[k].x, directed_rows[k].y, directed_rows[k].last,
                    $urandom_range(0, 13), directed_rows[k].kind);
      while (items_sent < ITEM_GOAL) begin
         // Mostly small sets; now and then one that fills or overruns the store.
         n = ($urandom_range(0, 24) == 0) ? $urandom_range(NPTS, NPTS + 2)
                                          : $urandom_range(1, 5);
         flavor = $urandom_range(0, 2);
         idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 1;
         for (int k = 0; k < n; k++)
            send_point(draw_value(flavor), draw_value(flavor), k == n - 1,
                       idle_pct * $urandom_range(0, 13), CHK_PREDICT);
      end
      start = 1'b0;
      wait_lim = 0;
      while (coef_due_q.size() != 0) begin
         @(negedge clock);
         wait_lim++;
         if (wait_lim > 200000) begin
            $display("Verification failed");
            $finish;
         end
      end
      repeat (200) @(negedge clock);
      if (error_count == 0 && coef_due_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

### files.f
hw/rtl/lce_pkg.sv
hw/rtl/lce_ram.sv
hw/rtl/lce_queue.sv
hw/rtl/lce_mul.sv
hw/rtl/lce_div.sv
hw/rtl/lce_front.sv
hw/rtl/lce_back.sv
hw/rtl/lagrange_coefficient_engine_unit.sv
verif/tb_lagrange_coefficient_engine_unit.sv
